/* rtl/tgi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_pkg
// Shared constants, types and helpers for the trilinear grid interpolator:
// grid geometry, bank split by corner parity and blend widths.
// ----------------------------------------------------------------------------
package tgi_pkg;

  // Grid geometry (power-of-two axes, product equal to the store depth)
  localparam int ROWS       = 64;
  localparam int COLS       = 64;
  localparam int ANGLES     = 16;
  localparam int FRAC_BITS  = 8;
  localparam int VALUE_BITS = 16;

  localparam int ADDR_W    = 16;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLS);
  localparam int ANG_W     = $clog2(ANGLES);
  localparam int ROW_POS_W = 14;
  localparam int COL_POS_W = 14;
  localparam int ANG_POS_W = 12;
  localparam int ROW_INT_W = ROW_POS_W - FRAC_BITS;
  localparam int COL_INT_W = COL_POS_W - FRAC_BITS;

  // Eight banks, one per (angle, row, column) parity
  localparam int BANKS       = 8;
  localparam int BANK_SEL_W  = 3;
  localparam int BANK_ADDR_W = ADDR_W - BANK_SEL_W;
  localparam int BANK_DEPTH  = 1 << BANK_ADDR_W;

  // Blend widths: each axis adds FRAC_BITS of weight
  localparam int WGT_W = FRAC_BITS + 1;
  localparam int L1_W  = VALUE_BITS + FRAC_BITS;
  localparam int L2_W  = L1_W + FRAC_BITS;
  localparam int L3_W  = L2_W + FRAC_BITS;
  localparam int RND_SHIFT = 3 * FRAC_BITS;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [VALUE_BITS-1:0]  sample_t;
  typedef logic [FRAC_BITS-1:0]   frac_t;
  typedef logic [WGT_W-1:0]       wgt_t;
  typedef logic [BANK_ADDR_W-1:0] bank_addr_t;
  typedef logic [BANK_SEL_W-1:0]  bank_sel_t;

  // Corner geometry carried alongside a query
  typedef struct packed {
    logic  a_par;
    logic  r_par;
    logic  c_par;
    logic  r_clamp;
    logic  c_clamp;
    frac_t r_frac;
    frac_t c_frac;
    frac_t a_frac;
  } geom_t;

  // Weight of the lower corner: one minus the fraction
  function automatic wgt_t wgt_lo(frac_t f);
    wgt_t one;
    one = wgt_t'(1) << FRAC_BITS;
    return one - wgt_t'(f);
  endfunction

  function automatic wgt_t wgt_hi(frac_t f);
    return wgt_t'(f);
  endfunction

endpackage

/* rtl/tgi_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_ram
// Generic single-write, single-read RAM with registered read data that
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module tgi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold on stall
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/trilinear_grid_interpolator.sv */
// A query beat passes stage 0, the bank read, the blends and the output register.
// Throughput: one beat (write or query) per cycle; in_ready drops only on output stall.
// The grid is split into eight RAM banks by corner parity, so all eight corners
// are read in the same cycle; the column, row and angle blends take a stage each.
// Reset clears the pipeline valid bits only; grid contents are undefined until
// written, and there is no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator
// Grid of signed samples by angle, row and column with trilinear lookup;
// the angle axis wraps, row and column clamp at the edge.
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [tgi_pkg::ADDR_W-1:0]      in_write_addr,
  input  logic signed [tgi_pkg::VALUE_BITS-1:0] in_write_value,
  input  logic [tgi_pkg::ROW_POS_W-1:0]   in_row_pos,
  input  logic [tgi_pkg::COL_POS_W-1:0]   in_col_pos,
  input  logic [tgi_pkg::ANG_POS_W-1:0]   in_angle_pos,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [tgi_pkg::VALUE_BITS-1:0] out_interp_value
);

  localparam int RH_W = tgi_pkg::ROW_W - 1;
  localparam int CH_W = tgi_pkg::COL_W - 1;
  localparam int AH_W = tgi_pkg::ANG_W - 1;

  // Stage loads
  logic out_load, s4_load, s3_load, s2_load, s1_load, s0_load;

  // Input decode
  logic [tgi_pkg::ROW_INT_W-1:0] r_int;
  logic [tgi_pkg::COL_INT_W-1:0] c_int;
  logic [tgi_pkg::ROW_W-1:0]     r0;
  logic [tgi_pkg::COL_W-1:0]     c0;
  logic [tgi_pkg::ANG_W-1:0]     a0;
  tgi_pkg::geom_t                geom_nxt;
  tgi_pkg::bank_addr_t           raddr_nxt [tgi_pkg::BANKS];
  logic [tgi_pkg::ANG_W-1:0]     wa;
  logic [tgi_pkg::ROW_W-1:0]     wr;
  logic [tgi_pkg::COL_W-1:0]     wc;
  tgi_pkg::bank_sel_t            wbank_nxt;
  tgi_pkg::bank_addr_t           waddr_nxt;
  logic [AH_W-1:0]               a_half;
  logic [RH_W-1:0]               r_half;
  logic [CH_W-1:0]               c_half;

  // Stage 0: captured beat
  logic                s0_v_r;
  logic                s0_query_r;
  tgi_pkg::bank_sel_t  s0_wbank_r;
  tgi_pkg::bank_addr_t s0_waddr_r;
  tgi_pkg::sample_t    s0_wdata_r;
  tgi_pkg::bank_addr_t s0_raddr_r [tgi_pkg::BANKS];
  tgi_pkg::geom_t      s0_geom_r;

  // Stage 1: bank read data
  logic                s1_v_r;
  tgi_pkg::geom_t      s1_geom_r;
  tgi_pkg::sample_t    bank_rd [tgi_pkg::BANKS];

  // Stage 2: column blend
  logic                      s2_v_r;
  tgi_pkg::frac_t            s2_r_frac_r;
  tgi_pkg::frac_t            s2_a_frac_r;
  logic [tgi_pkg::L1_W-1:0]  s2_l1_r   [4];
  logic [tgi_pkg::L1_W-1:0]  s2_l1_nxt [4];
  tgi_pkg::sample_t          corner    [8];

  // Stage 3: row blend
  logic                      s3_v_r;
  tgi_pkg::frac_t            s3_a_frac_r;
  logic [tgi_pkg::L2_W-1:0]  s3_l2_r   [2];
  logic [tgi_pkg::L2_W-1:0]  s3_l2_nxt [2];

  // Stage 4: angle blend
  logic                      s4_v_r;
  logic [tgi_pkg::L3_W-1:0]  s4_l3_r;
  logic [tgi_pkg::L3_W-1:0]  s4_l3_nxt;

  // Output register
  logic                      out_valid_r;
  tgi_pkg::sample_t          out_value_r;
  tgi_pkg::sample_t          out_value_nxt;
  logic [tgi_pkg::L3_W:0]    rounded;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    out_load = !out_valid_r || out_ready;
    s4_load  = !s4_v_r || out_load;
    s3_load  = !s3_v_r || s4_load;
    s2_load  = !s2_v_r || s3_load;
    s1_load  = !s1_v_r || s2_load;
    s0_load  = !s0_v_r || s1_load;
  end

  assign in_ready = s0_load;

  // Decode query corners and write address
  always_comb begin
    r_int = in_row_pos[tgi_pkg::ROW_POS_W-1:tgi_pkg::FRAC_BITS];
    c_int = in_col_pos[tgi_pkg::COL_POS_W-1:tgi_pkg::FRAC_BITS];
    // clamp lower corner to the last row / column
    if ({1'b0, r_int} > (tgi_pkg::ROW_INT_W+1)'(tgi_pkg::ROWS - 1)) begin
      r0 = tgi_pkg::ROW_W'(tgi_pkg::ROWS - 1);
    end else begin
      r0 = r_int[tgi_pkg::ROW_W-1:0];
    end
    if ({1'b0, c_int} > (tgi_pkg::COL_INT_W+1)'(tgi_pkg::COLS - 1)) begin
      c0 = tgi_pkg::COL_W'(tgi_pkg::COLS - 1);
    end else begin
      c0 = c_int[tgi_pkg::COL_W-1:0];
    end
    // angle index wraps modulo the axis size
    a0 = in_angle_pos[tgi_pkg::FRAC_BITS +: tgi_pkg::ANG_W];

    geom_nxt.a_par   = a0[0];
    geom_nxt.r_par   = r0[0];
    geom_nxt.c_par   = c0[0];
    geom_nxt.r_clamp = (r0 == tgi_pkg::ROW_W'(tgi_pkg::ROWS - 1));
    geom_nxt.c_clamp = (c0 == tgi_pkg::COL_W'(tgi_pkg::COLS - 1));
    geom_nxt.r_frac  = in_row_pos[tgi_pkg::FRAC_BITS-1:0];
    geom_nxt.c_frac  = in_col_pos[tgi_pkg::FRAC_BITS-1:0];
    geom_nxt.a_frac  = in_angle_pos[tgi_pkg::FRAC_BITS-1:0];

    // Each bank holds one parity per axis: take the lower or the upper corner
    // whichever has that parity; an odd lower index steps the half-index
    for (int b = 0; b < tgi_pkg::BANKS; b++) begin
      a_half = a0[tgi_pkg::ANG_W-1:1] + AH_W'(a0[0] && !b[2]);
      r_half = r0[tgi_pkg::ROW_W-1:1] + RH_W'(r0[0] && !b[1]);
      c_half = c0[tgi_pkg::COL_W-1:1] + CH_W'(c0[0] && !b[0]);
      raddr_nxt[b] = {a_half, r_half, c_half};
    end

    // Split the flat write address into bank and bank offset
    {wa, wr, wc} = in_write_addr;
    wbank_nxt = {wa[0], wr[0], wc[0]};
    waddr_nxt = {wa[tgi_pkg::ANG_W-1:1], wr[tgi_pkg::ROW_W-1:1], wc[tgi_pkg::COL_W-1:1]};
  end

  // Stage 0 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_load) begin
      s0_v_r <= in_valid;
    end
  end

  // Stage 0 payload
  always_ff @(posedge clk) begin
    if (s0_load && in_valid) begin
      s0_query_r <= (in_op == tgi_pkg::OP_QUERY);
      s0_wbank_r <= wbank_nxt;
      s0_waddr_r <= waddr_nxt;
      s0_wdata_r <= in_write_value;
      s0_raddr_r <= raddr_nxt;
      s0_geom_r  <= geom_nxt;
    end
  end

  // Grid banks: write as a write beat leaves stage 0, read as stage 1 loads
  for (genvar b = 0; b < tgi_pkg::BANKS; b++) begin : g_bank
    tgi_ram #(
      .WIDTH (tgi_pkg::VALUE_BITS),
      .DEPTH (tgi_pkg::BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (s0_v_r && !s0_query_r && s1_load &&
              (s0_wbank_r == tgi_pkg::BANK_SEL_W'(b))),
      .waddr (s0_waddr_r),
      .wdata (s0_wdata_r),
      .re    (s1_load),
      .raddr (s0_raddr_r[b]),
      .rdata (bank_rd[b])
    );
  end

  // Stage 1: drop write beats, carry query geometry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= s0_v_r && s0_query_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_geom_r <= s0_geom_r;
    end
  end

  // Route banks to corners, bias to unsigned, blend along the column
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      // a clamped upper corner reuses the lower corner's bank
      corner[i] = bank_rd[{s1_geom_r.a_par ^ i[2],
                           s1_geom_r.r_par ^ (i[1] && !s1_geom_r.r_clamp),
                           s1_geom_r.c_par ^ (i[0] && !s1_geom_r.c_clamp)}]
                  ^ {1'b1, {(tgi_pkg::VALUE_BITS-1){1'b0}}};
    end
    for (int j = 0; j < 4; j++) begin
      s2_l1_nxt[j] = tgi_pkg::L1_W'(
          tgi_pkg::L1_W'(corner[2*j])     * tgi_pkg::L1_W'(tgi_pkg::wgt_lo(s1_geom_r.c_frac))
        + tgi_pkg::L1_W'(corner[2*j + 1]) * tgi_pkg::L1_W'(tgi_pkg::wgt_hi(s1_geom_r.c_frac)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_load) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_l1_r     <= s2_l1_nxt;
      s2_r_frac_r <= s1_geom_r.r_frac;
      s2_a_frac_r <= s1_geom_r.a_frac;
    end
  end

  // Blend along the row
  always_comb begin
    for (int x = 0; x < 2; x++) begin
      s3_l2_nxt[x] = tgi_pkg::L2_W'(
          tgi_pkg::L2_W'(s2_l1_r[2*x])     * tgi_pkg::L2_W'(tgi_pkg::wgt_lo(s2_r_frac_r))
        + tgi_pkg::L2_W'(s2_l1_r[2*x + 1]) * tgi_pkg::L2_W'(tgi_pkg::wgt_hi(s2_r_frac_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_load) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_l2_r     <= s3_l2_nxt;
      s3_a_frac_r <= s2_a_frac_r;
    end
  end

  // Blend along the angle
  always_comb begin
    s4_l3_nxt = tgi_pkg::L3_W'(
        tgi_pkg::L3_W'(s3_l2_r[0]) * tgi_pkg::L3_W'(tgi_pkg::wgt_lo(s3_a_frac_r))
      + tgi_pkg::L3_W'(s3_l2_r[1]) * tgi_pkg::L3_W'(tgi_pkg::wgt_hi(s3_a_frac_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_load) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_load) begin
      s4_l3_r <= s4_l3_nxt;
    end
  end

  // Round half up, drop the weight scale, remove the bias; the blend of
  // in-range samples never leaves the sample range, so no clipping is needed
  always_comb begin
    rounded = {1'b0, s4_l3_r} + ((tgi_pkg::L3_W+1)'(1) << (tgi_pkg::RND_SHIFT - 1));
    out_value_nxt = rounded[tgi_pkg::RND_SHIFT +: tgi_pkg::VALUE_BITS]
                    ^ {1'b1, {(tgi_pkg::VALUE_BITS-1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;

endmodule

/* rtl/tgi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_checker
// Port-level checks for the trilinear grid interpolator: result count
// against query beats, output hold, readiness and reset behaviour.
// ----------------------------------------------------------------------------
module tgi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tgi_pkg::VALUE_BITS-1:0] out_interp_value
);

  localparam int PIPE_DEPTH = 6;

  logic [3:0] pend_r;
  logic [3:0] pend_nxt;
  logic       q_in;
  logic       q_out;

  // Track query beats still owed a result
  always_comb begin
    q_in     = in_valid && in_ready && (in_op == tgi_pkg::OP_QUERY);
    q_out    = out_valid && out_ready;
    pend_nxt = pend_r + 4'(q_in) - 4'(q_out);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A result beat needs an outstanding query
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 4'd0))
    else $error("result beat without an outstanding query");

  // Outstanding queries never exceed the pipeline depth
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'(PIPE_DEPTH))
    else $error("more queries in flight than pipeline stages");

  // With no result waiting, the input side is open
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_interp_value))
    else $error("stalled result beat changed");

  // Nothing leaves straight after reset
  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind trilinear_grid_interpolator tgi_checker u_tgi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_op            (in_op),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_interp_value (out_interp_value)
);
